>>> rtl/core/dlle_pkg.sv
// ============================================================================
// dlle_pkg: shared types and constants of the doubly linked list engine
// Pool size, pointer widths, request and status codes, item structs.
// ============================================================================
`default_nettype none

package dlle_pkg;

    // node pool size and derived widths
    localparam int CAPACITY = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PTR_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int LEN_W    = 6;

    // null link code, one past the last node
    localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

    typedef enum logic [2:0] {
        REQ_INS_HEAD = 3'd0,
        REQ_INS_TAIL = 3'd1,
        REQ_INS_AT   = 3'd2,
        REQ_DEL_HEAD = 3'd3,
        REQ_DEL_TAIL = 3'd4,
        REQ_DEL_AT   = 3'd5,
        REQ_READ_FWD = 3'd6,
        REQ_READ_REV = 3'd7
    } req_code_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_OOB   = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        req_code_t                  req_type;
        logic signed [VALUE_W-1:0]  value;
        logic [POS_W-1:0]           position;
    } req_t;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  value_out;
        logic                       last;
        logic [LEN_W-1:0]           length;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/dlle_ram.sv
// ============================================================================
// dlle_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; read returns old data on
// a same-address collision.
// ============================================================================
`default_nettype none

module dlle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/doubly_linked_list_engine_unit.sv
// ============================================================================
// doubly_linked_list_engine_unit: linked list of signed values in node memories
// Insert, delete and read requests on a doubly linked list kept in three
// synchronous memories (value, next link, prev link).
// ============================================================================
// sequence: a rejected request (out of bounds, full, empty) strobes its result
//   in the cycle after the accept; an insert/delete at position p walks the
//   next links in ST_WALK, then passes ST_INS_RD, ST_INS_LINK and ST_INS_FIX
//   (or ST_DEL_RD, ST_DEL_UNLINK and ST_DEL_FIX) into the result register; a
//   read of n elements fetches its first node, then strobes one item per cycle
// issue: one request at a time, taken only while idle; a rejection leaves the
//   block idle, other requests keep it busy until their final result, walking
//   the link memories one node per cycle through their registered read port
// reset: rst_n clears the control state, then a pass over all CAPACITY nodes
//   rebuilds the free list in the link memories while busy stays high
// results leave on a one-cycle strobe; the receiver cannot stall
`default_nettype none

module doubly_linked_list_engine_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire dlle_pkg::req_t   req,
    output logic                  busy,
    output dlle_pkg::result_t     result,
    output logic                  result_valid
);

    localparam int AW = dlle_pkg::ADDR_W;
    localparam int PW = dlle_pkg::PTR_W;
    localparam int VW = dlle_pkg::VALUE_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_INS_RD,
        ST_INS_LINK,
        ST_INS_FIX,
        ST_DEL_RD,
        ST_DEL_UNLINK,
        ST_DEL_FIX,
        ST_READ
    } state_t;

    // sequencer registers
    state_t              state_reg,     state_next;
    logic [AW-1:0]       clr_reg,       clr_next;
    logic [PW-1:0]       cur_reg,       cur_next;      // walk / read pointer
    logic                pend_reg,      pend_next;     // link read in flight
    logic                rev_reg,       rev_next;      // follow prev links
    logic                is_ins_reg,    is_ins_next;
    logic [PW-1:0]       cnt_reg,       cnt_next;      // steps or items left
    logic [PW-1:0]       tgt_reg,       tgt_next;      // node at position
    logic [PW-1:0]       lnk_a_reg,     lnk_a_next;    // neighbor before
    logic [PW-1:0]       lnk_b_reg,     lnk_b_next;    // neighbor after
    logic [PW-1:0]       node_reg,      node_next;     // newly taken node
    logic [VW-1:0]       val_reg,       val_next;

    // list anchors
    logic [PW-1:0]       head_reg,      head_next;
    logic [PW-1:0]       tail_reg,      tail_next;
    logic [PW-1:0]       free_reg,      free_next;
    logic [PW-1:0]       count_reg,     count_next;

    // result register
    dlle_pkg::result_t   result_reg,    result_next;
    logic                result_valid_reg, result_valid_next;

    // memory ports
    logic                val_we;
    logic [AW-1:0]       val_waddr, val_raddr;
    logic [VW-1:0]       val_wdata, val_rdata;
    logic                nxt_we;
    logic [AW-1:0]       nxt_waddr, nxt_raddr;
    logic [PW-1:0]       nxt_wdata, nxt_rdata;
    logic                prv_we;
    logic [AW-1:0]       prv_waddr, prv_raddr;
    logic [PW-1:0]       prv_wdata, prv_rdata;

    logic [PW-1:0]       cur_c;
    logic [PW-1:0]       a_c;
    logic [8:0]          pos9;
    logic [8:0]          cnt9;
    logic [8:0]          p9;

    dlle_ram #(.WIDTH(VW), .DEPTH(dlle_pkg::CAPACITY)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    dlle_ram #(.WIDTH(PW), .DEPTH(dlle_pkg::CAPACITY)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (nxt_raddr),
        .rdata (nxt_rdata)
    );

    dlle_ram #(.WIDTH(PW), .DEPTH(dlle_pkg::CAPACITY)) u_prv_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (prv_raddr),
        .rdata (prv_rdata)
    );

    function automatic dlle_pkg::result_t mk_result(
        input dlle_pkg::status_t st,
        input logic [VW-1:0]     v,
        input logic              lst,
        input logic [PW-1:0]     cnt
    );
        dlle_pkg::result_t r;
        r.status    = st;
        r.value_out = v;
        r.last      = lst;
        r.length    = dlle_pkg::LEN_W'(cnt);
        return r;
    endfunction

    // pointer just fetched from a link memory, or the held one on the first step
    assign cur_c = pend_reg ? (rev_reg ? prv_rdata : nxt_rdata) : cur_reg;

    // predecessor of the insert point: tail when appending, else prev of target
    assign a_c = (tgt_reg == dlle_pkg::NIL) ? tail_reg : prv_rdata;

    assign pos9 = {1'b0, req.position};
    assign cnt9 = 9'(count_reg);

    // 1-based position the request refers to
    always_comb
    begin
        case (req.req_type)
            dlle_pkg::REQ_INS_HEAD: p9 = 9'd1;
            dlle_pkg::REQ_INS_TAIL: p9 = cnt9 + 9'd1;
            dlle_pkg::REQ_DEL_HEAD: p9 = 9'd1;
            dlle_pkg::REQ_DEL_TAIL: p9 = cnt9;
            default:                p9 = pos9;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        cur_next          = cur_reg;
        pend_next         = pend_reg;
        rev_next          = rev_reg;
        is_ins_next       = is_ins_reg;
        cnt_next          = cnt_reg;
        tgt_next          = tgt_reg;
        lnk_a_next        = lnk_a_reg;
        lnk_b_next        = lnk_b_reg;
        node_next         = node_reg;
        val_next          = val_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        free_next         = free_reg;
        count_next        = count_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        val_we    = 1'b0;
        val_waddr = free_reg[AW-1:0];
        val_wdata = val_reg;
        val_raddr = cur_c[AW-1:0];
        nxt_we    = 1'b0;
        nxt_waddr = tgt_reg[AW-1:0];
        nxt_wdata = free_reg;
        nxt_raddr = cur_c[AW-1:0];
        prv_we    = 1'b0;
        prv_waddr = tgt_reg[AW-1:0];
        prv_wdata = dlle_pkg::NIL;
        prv_raddr = cur_c[AW-1:0];

        case (state_reg)
            // rebuild the free list: node i links to i+1, prev links are null
            ST_CLEAR:
            begin
                nxt_we    = 1'b1;
                nxt_waddr = clr_reg;
                nxt_wdata = PW'(clr_reg) + PW'(1);
                prv_we    = 1'b1;
                prv_waddr = clr_reg;
                prv_wdata = dlle_pkg::NIL;
                if (clr_reg == AW'(dlle_pkg::CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    pend_next = 1'b0;
                    rev_next  = 1'b0;
                    case (req.req_type)
                        dlle_pkg::REQ_INS_HEAD,
                        dlle_pkg::REQ_INS_TAIL,
                        dlle_pkg::REQ_INS_AT:
                        begin
                            if (p9 == 9'd0 || p9 > cnt9 + 9'd1)
                            begin
                                result_next = mk_result(dlle_pkg::STATUS_OOB, '0, 1'b1,
                                                        count_reg);
                                result_valid_next = 1'b1;
                            end
                            else if (count_reg == PW'(dlle_pkg::CAPACITY))
                            begin
                                result_next = mk_result(dlle_pkg::STATUS_FULL, '0, 1'b1,
                                                        count_reg);
                                result_valid_next = 1'b1;
                            end
                            else
                            begin
                                is_ins_next = 1'b1;
                                val_next    = req.value;
                                // past the end the new node goes after the tail
                                if (p9 > cnt9)
                                begin
                                    cur_next = dlle_pkg::NIL;
                                    cnt_next = '0;
                                end
                                else
                                begin
                                    cur_next = head_reg;
                                    cnt_next = PW'(p9 - 9'd1);
                                end
                                state_next = ST_WALK;
                            end
                        end

                        dlle_pkg::REQ_DEL_HEAD,
                        dlle_pkg::REQ_DEL_TAIL,
                        dlle_pkg::REQ_DEL_AT:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next = mk_result(dlle_pkg::STATUS_EMPTY, '0, 1'b1,
                                                        count_reg);
                                result_valid_next = 1'b1;
                            end
                            else if (p9 == 9'd0 || p9 > cnt9)
                            begin
                                result_next = mk_result(dlle_pkg::STATUS_OOB, '0, 1'b1,
                                                        count_reg);
                                result_valid_next = 1'b1;
                            end
                            else
                            begin
                                is_ins_next = 1'b0;
                                if (req.req_type == dlle_pkg::REQ_DEL_TAIL)
                                begin
                                    cur_next = tail_reg;
                                    cnt_next = '0;
                                end
                                else
                                begin
                                    cur_next = head_reg;
                                    cnt_next = PW'(p9 - 9'd1);
                                end
                                state_next = ST_WALK;
                            end
                        end

                        dlle_pkg::REQ_READ_FWD,
                        dlle_pkg::REQ_READ_REV:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next = mk_result(dlle_pkg::STATUS_EMPTY, '0, 1'b1,
                                                        count_reg);
                                result_valid_next = 1'b1;
                            end
                            else
                            begin
                                rev_next   = (req.req_type == dlle_pkg::REQ_READ_REV);
                                cur_next   = (req.req_type == dlle_pkg::REQ_READ_REV)
                                             ? tail_reg : head_reg;
                                cnt_next   = count_reg;
                                state_next = ST_READ;
                            end
                        end

                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // follow next links one node per cycle
            ST_WALK:
            begin
                nxt_raddr = cur_c[AW-1:0];
                cur_next  = cur_c;
                if (cnt_reg == '0)
                begin
                    tgt_next   = cur_c;
                    pend_next  = 1'b0;
                    state_next = is_ins_reg ? ST_INS_RD : ST_DEL_RD;
                end
                else
                begin
                    cnt_next  = cnt_reg - PW'(1);
                    pend_next = 1'b1;
                end
            end

            // fetch the free list successor and the target's predecessor
            ST_INS_RD:
            begin
                nxt_raddr  = free_reg[AW-1:0];
                prv_raddr  = tgt_reg[AW-1:0];
                state_next = ST_INS_LINK;
            end

            ST_INS_LINK:
            begin
                val_we     = 1'b1;
                val_waddr  = free_reg[AW-1:0];
                val_wdata  = val_reg;
                nxt_we     = 1'b1;
                nxt_waddr  = free_reg[AW-1:0];
                nxt_wdata  = tgt_reg;
                prv_we     = 1'b1;
                prv_waddr  = free_reg[AW-1:0];
                prv_wdata  = a_c;
                lnk_a_next = a_c;
                node_next  = free_reg;
                free_next  = nxt_rdata;
                state_next = ST_INS_FIX;
            end

            // hook the neighbors onto the new node
            ST_INS_FIX:
            begin
                if (lnk_a_reg != dlle_pkg::NIL)
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = lnk_a_reg[AW-1:0];
                    nxt_wdata = node_reg;
                end
                else
                begin
                    head_next = node_reg;
                end
                if (tgt_reg != dlle_pkg::NIL)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = tgt_reg[AW-1:0];
                    prv_wdata = node_reg;
                end
                else
                begin
                    tail_next = node_reg;
                end
                count_next        = count_reg + PW'(1);
                result_next       = mk_result(dlle_pkg::STATUS_OK, '0, 1'b1,
                                              count_reg + PW'(1));
                result_valid_next = 1'b1;
                state_next        = ST_IDLE;
            end

            ST_DEL_RD:
            begin
                nxt_raddr  = tgt_reg[AW-1:0];
                prv_raddr  = tgt_reg[AW-1:0];
                state_next = ST_DEL_UNLINK;
            end

            // push the node onto the free list, fix head and tail
            ST_DEL_UNLINK:
            begin
                nxt_we     = 1'b1;
                nxt_waddr  = tgt_reg[AW-1:0];
                nxt_wdata  = free_reg;
                prv_we     = 1'b1;
                prv_waddr  = tgt_reg[AW-1:0];
                prv_wdata  = dlle_pkg::NIL;
                free_next  = tgt_reg;
                lnk_a_next = prv_rdata;
                lnk_b_next = nxt_rdata;
                if (prv_rdata == dlle_pkg::NIL)
                begin
                    head_next = nxt_rdata;
                end
                if (nxt_rdata == dlle_pkg::NIL)
                begin
                    tail_next = prv_rdata;
                end
                count_next = count_reg - PW'(1);
                state_next = ST_DEL_FIX;
            end

            // join the neighbors around the removed node
            ST_DEL_FIX:
            begin
                if (lnk_a_reg != dlle_pkg::NIL)
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = lnk_a_reg[AW-1:0];
                    nxt_wdata = lnk_b_reg;
                end
                if (lnk_b_reg != dlle_pkg::NIL)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = lnk_b_reg[AW-1:0];
                    prv_wdata = lnk_a_reg;
                end
                result_next       = mk_result(dlle_pkg::STATUS_OK, '0, 1'b1, count_reg);
                result_valid_next = 1'b1;
                state_next        = ST_IDLE;
            end

            // one node fetched per cycle, its value passed from the read port into the result register
            ST_READ:
            begin
                val_raddr = cur_c[AW-1:0];
                nxt_raddr = cur_c[AW-1:0];
                prv_raddr = cur_c[AW-1:0];
                cur_next  = cur_c;
                if (cnt_reg != '0)
                begin
                    cnt_next  = cnt_reg - PW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    result_next       = mk_result(dlle_pkg::STATUS_OK, val_rdata,
                                                  (cnt_reg == '0), count_reg);
                    result_valid_next = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            cur_reg          <= dlle_pkg::NIL;
            pend_reg         <= 1'b0;
            rev_reg          <= 1'b0;
            is_ins_reg       <= 1'b0;
            cnt_reg          <= '0;
            tgt_reg          <= dlle_pkg::NIL;
            lnk_a_reg        <= dlle_pkg::NIL;
            lnk_b_reg        <= dlle_pkg::NIL;
            node_reg         <= '0;
            val_reg          <= '0;
            head_reg         <= dlle_pkg::NIL;
            tail_reg         <= dlle_pkg::NIL;
            free_reg         <= '0;
            count_reg        <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            cur_reg          <= cur_next;
            pend_reg         <= pend_next;
            rev_reg          <= rev_next;
            is_ins_reg       <= is_ins_next;
            cnt_reg          <= cnt_next;
            tgt_reg          <= tgt_next;
            lnk_a_reg        <= lnk_a_next;
            lnk_b_reg        <= lnk_b_next;
            node_reg         <= node_next;
            val_reg          <= val_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            free_reg         <= free_next;
            count_reg        <= count_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/dlle_checker.sv
// ============================================================================
// dlle_checker: port-level checks of the linked list engine
// Watches request and result ports for sequencing slips.
// ============================================================================
`default_nettype none

module dlle_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire dlle_pkg::req_t    req,
    input wire logic              busy,
    input wire dlle_pkg::result_t result,
    input wire logic              result_valid
);

    // an accepted item either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || result_valid)
        else $error("accepted item neither answered nor busy");

    // a read run has no gaps
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid)
        else $error("gap inside a read run");

    // a rejected request gives a single final item
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != dlle_pkg::STATUS_OK |-> result.last)
        else $error("error status without last mark");

    // the final item frees the request port
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("still busy on the final item");

    // empty status only with an empty list
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == dlle_pkg::STATUS_EMPTY |-> result.length == '0)
        else $error("empty status with nonzero length");

endmodule

bind doubly_linked_list_engine_unit dlle_checker u_dlle_checker (.*);

`default_nettype wire
